// ===== src/msm_pkg.sv =====
package msm_pkg;

	// Fixed field widths of the transaction payload.
	localparam int BYTE_W = 8;
	localparam int SLOT_W = 3;
	localparam int IDX_W  = 4;

	// Action codes carried by an input transaction.
	typedef enum logic [1:0] {
		ACT_STREAM = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_LENGTH = 2'd2,
		ACT_CLEAR  = 2'd3
	} act_t;

	// Controls for the stream history.
	typedef struct packed {
		logic shift;
		logic clear;
	} hist_ctl_t;

	// Write command into the pattern store.
	typedef struct packed {
		logic              byte_we;
		logic              len_we;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
	} pat_wr_t;

endpackage

// ===== src/msm_pat_store.sv =====
module msm_pat_store
	import msm_pkg::*;
#(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 16,
	localparam int LW = $clog2(MAX_PATTERN_LEN + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pat_wr_t           wr,
	output logic [BYTE_W-1:0] pat_bytes [NUM_PATTERNS][MAX_PATTERN_LEN],
	output logic [LW-1:0]     pat_len [NUM_PATTERNS]
);

	logic [BYTE_W-1:0] bytes_q [NUM_PATTERNS][MAX_PATTERN_LEN];
	logic [LW-1:0]     len_q [NUM_PATTERNS];
	logic [LW-1:0]     len_wr;

	// Lengths above the maximum saturate at the maximum.
	assign len_wr = (int'(wr.data) > MAX_PATTERN_LEN) ? LW'(MAX_PATTERN_LEN)
		: wr.data[LW-1:0];

	// Pattern bytes hold no reset value; writes to slots or positions out of range are ignored.
	always_ff @(posedge clk) begin
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
				if (wr.byte_we && int'(wr.slot) == s && int'(wr.idx) == k) begin
					bytes_q[s][k] <= wr.data;
				end
			end
		end
	end

	// Lengths reset to zero, which disables every slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				len_q[s] <= '0;
			end
		end else begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				if (wr.len_we && int'(wr.slot) == s) begin
					len_q[s] <= len_wr;
				end
			end
		end
	end

	assign pat_bytes = bytes_q;
	assign pat_len   = len_q;

endmodule

// ===== src/msm_hist.sv =====
module msm_hist
	import msm_pkg::*;
#(
	parameter int MAX_PATTERN_LEN = 16,
	localparam int LW = $clog2(MAX_PATTERN_LEN + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hist_ctl_t         ctl,
	input  logic [BYTE_W-1:0] value,
	output logic [BYTE_W-1:0] hist_view [MAX_PATTERN_LEN],
	output logic [LW-1:0]     fill_view,
	output logic [LW-1:0]     fill_cur
);

	logic [BYTE_W-1:0] hist_q [MAX_PATTERN_LEN];
	logic [LW-1:0]     fill_q;
	logic [LW-1:0]     fill_next;

	// The view shows the history as it stands once the new byte is shifted in.
	always_comb begin
		hist_view[0] = value;
		for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
			hist_view[j] = hist_q[j-1];
		end
	end

	// Byte count since the last clear, saturating at the maximum length.
	assign fill_next = (fill_q == LW'(MAX_PATTERN_LEN)) ? fill_q : fill_q + LW'(1);
	assign fill_view = fill_next;
	assign fill_cur  = fill_q;

	// History bytes beyond the fill count are never compared, so they need no reset.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hist_q[0] <= value;
			for (int j = 1; j < MAX_PATTERN_LEN; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end
	end

	// A clear takes priority over the count step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.clear) begin
			fill_q <= '0;
		end else if (ctl.shift) begin
			fill_q <= fill_next;
		end
	end

endmodule

// ===== src/msm_slot_cmp.sv =====
module msm_slot_cmp
	import msm_pkg::*;
#(
	parameter int MAX_PATTERN_LEN = 16,
	localparam int LW = $clog2(MAX_PATTERN_LEN + 1),
	localparam int IW = $clog2(MAX_PATTERN_LEN)
) (
	input  logic [BYTE_W-1:0] pat [MAX_PATTERN_LEN],
	input  logic [LW-1:0]     len,
	input  logic [BYTE_W-1:0] hist [MAX_PATTERN_LEN],
	input  logic [LW-1:0]     fill,
	output logic              hit
);

	logic [MAX_PATTERN_LEN-1:0] byte_ok;

	// Pattern byte k lines up with the history entry len-1-k; bytes past the length pass.
	for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_byte
		logic [LW-1:0] rel;
		logic [IW-1:0] pos;

		assign rel = len - LW'(k) - LW'(1);
		assign pos  = rel[IW-1:0];
		assign byte_ok[k] = (LW'(k) >= len) || (pat[k] == hist[pos]);
	end

	// An enabled slot needs enough bytes seen since the last clear.
	assign hit = (len != '0) && (fill >= len) && (&byte_ok);

endmodule

// ===== src/multi_pattern_suffix_matcher.sv =====
// Multi-pattern suffix matcher.
// Input channel (in_valid/in_ready) carries one transaction per item: action,
// slot, byte_index and value. Action stream feeds a byte, write loads one
// pattern byte, length sets a slot length (zero disables, larger than the
// maximum saturates) and clear empties the history.
// Output channel (out_valid/out_ready) returns one transaction per input
// transaction, in order: matched and the lowest matching slot. Only a stream
// byte can match; a match also empties the history.
// Path: a transaction is held in the input register, then its result is held in
// the result register, where it stays valid until out_ready takes it.
// Throughput: one transaction per cycle unless the result register is stalled;
// every slot is compared in parallel in one pass between the two registers.
// Stall: while the result register is held by a low out_ready, one more
// transaction is taken into the input register, then in_ready drops.
// Reset: all slots are disabled, the history is empty and both channels are
// idle. Pattern bytes are not cleared; load a slot's bytes before its length.
module multi_pattern_suffix_matcher
	import msm_pkg::*;
#(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [IDX_W-1:0]  byte_index,
	input  logic [BYTE_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched,
	output logic [SLOT_W-1:0] match_slot
);

	localparam int LW = $clog2(MAX_PATTERN_LEN + 1);

	logic              valid_s1;
	act_t              action_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [IDX_W-1:0]  index_s1;
	logic [BYTE_W-1:0] value_s1;

	logic              out_valid_q;
	logic              matched_q;
	logic [SLOT_W-1:0] match_slot_q;

	logic              advance;
	logic              fire_s1;
	logic              is_stream;
	hist_ctl_t         hist_ctl;
	pat_wr_t           pat_wr;

	logic [BYTE_W-1:0] hist_view [MAX_PATTERN_LEN];
	logic [LW-1:0]     fill_view;
	logic [LW-1:0]     fill_cur;
	logic [BYTE_W-1:0] pat_bytes [NUM_PATTERNS][MAX_PATTERN_LEN];
	logic [LW-1:0]     pat_len [NUM_PATTERNS];
	logic [NUM_PATTERNS-1:0] slot_hit;
	logic              any_hit;
	logic [SLOT_W-1:0] hit_slot;

	// Handshake: the input register moves on whenever the result register can take it.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire_s1  = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= act_t'(action);
			slot_s1   <= slot;
			index_s1  <= byte_index;
			value_s1  <= value;
		end
	end

	// Decode the registered transaction into history and store commands.
	always_comb begin
		is_stream      = 1'b0;
		pat_wr.byte_we = 1'b0;
		pat_wr.len_we  = 1'b0;
		pat_wr.slot    = slot_s1;
		pat_wr.idx     = index_s1;
		pat_wr.data    = value_s1;
		case (action_s1)
			ACT_STREAM: is_stream      = 1'b1;
			ACT_WRITE:  pat_wr.byte_we = fire_s1;
			ACT_LENGTH: pat_wr.len_we  = fire_s1;
			ACT_CLEAR:  is_stream      = 1'b0;
			default:    is_stream      = 1'b0;
		endcase
		hist_ctl.shift = fire_s1 && is_stream;
		hist_ctl.clear = fire_s1 && ((action_s1 == ACT_CLEAR) || (is_stream && any_hit));
	end

	msm_hist #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hist_ctl),
		.value    (value_s1),
		.hist_view(hist_view),
		.fill_view(fill_view),
		.fill_cur (fill_cur)
	);

	msm_pat_store #(
		.NUM_PATTERNS   (NUM_PATTERNS),
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
	) u_pat_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (pat_wr),
		.pat_bytes(pat_bytes),
		.pat_len  (pat_len)
	);

	// One comparator per slot, all working on the same history view.
	for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_slot
		msm_slot_cmp #(
			.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
		) u_slot_cmp (
			.pat (pat_bytes[s]),
			.len (pat_len[s]),
			.hist(hist_view),
			.fill(fill_view),
			.hit (slot_hit[s])
		);
	end

	// The lowest-numbered matching slot wins.
	always_comb begin
		hit_slot = '0;
		for (int s = NUM_PATTERNS - 1; s >= 0; s--) begin
			if (slot_hit[s]) begin
				hit_slot = SLOT_W'(s);
			end
		end
	end

	assign any_hit = |slot_hit;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			matched_q    <= is_stream && any_hit;
			match_slot_q <= (is_stream && any_hit) ? hit_slot : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign match_slot = match_slot_q;

	// A stream match restarts the byte count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && is_stream && any_hit) |=> (fill_cur == '0))
		else $error("fill count not cleared after a match");

	// A clear transaction restarts the byte count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && action_s1 == ACT_CLEAR) |=> (fill_cur == '0))
		else $error("fill count not cleared by a clear transaction");

	// Anything other than a stream byte reports no match and slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && action_s1 != ACT_STREAM) |=> (out_valid_q && !matched_q
		&& match_slot_q == '0))
		else $error("non-stream transaction produced a match");

	// The input side only stalls behind a full, stalled result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a stalled result");

	// A stream byte without a match advances the count by one up to the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && is_stream && !any_hit) |=> (fill_cur == $past(fill_view)))
		else $error("fill count did not step after a stream byte");

endmodule

// ===== bench/multi_pattern_suffix_matcher_tb.sv =====
module multi_pattern_suffix_matcher_tb;
	import msm_pkg::*;

	localparam int NPAT        = 8;
	localparam int MAXL        = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic              matched;
		logic [SLOT_W-1:0] slot;
	} match_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        action;
	logic [SLOT_W-1:0] slot;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] value;
	logic              out_valid;
	logic              out_ready;
	logic              matched;
	logic [SLOT_W-1:0] match_slot;

	multi_pattern_suffix_matcher #(
		.NUM_PATTERNS   (NPAT),
		.MAX_PATTERN_LEN(MAXL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.slot      (slot),
		.byte_index(byte_index),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched),
		.match_slot(match_slot)
	);

	// Mirror of the block state, newest stream byte at entry 0.
	logic [BYTE_W-1:0] hist_bytes [MAXL];
	int                hist_fill;
	logic [BYTE_W-1:0] pat_mem [NPAT][MAXL];
	int                pat_len [NPAT];
	// Tracks which pattern bytes were loaded, so that no enabled slot covers
	// a byte that was never written.
	bit                pat_written [NPAT][MAXL];

	match_t pending_matches[$];
	int     errors;
	int     items_sent;
	int     cycles;
	bit     sender_idles;
	bit     receiver_stalls;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void wipe_history();
		for (int k = 0; k < MAXL; k++)
			hist_bytes[k] = '0;
		hist_fill = 0;
	endfunction

	// A slot hits when its whole pattern equals the newest stream bytes, oldest first.
	function automatic bit slot_hit(int p);
		if (pat_len[p] == 0 || hist_fill < pat_len[p])
			return 1'b0;
		for (int k = 0; k < pat_len[p]; k++)
			if (pat_mem[p][k] !== hist_bytes[pat_len[p] - 1 - k])
				return 1'b0;
		return 1'b1;
	endfunction

	// Applies one accepted transaction to the mirrored state and returns its result.
	function automatic match_t predict_match(act_t act, logic [SLOT_W-1:0] s,
			logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] v);
		match_t res;
		res = '0;
		case (act)
			ACT_STREAM: begin
				for (int k = MAXL - 1; k > 0; k--)
					hist_bytes[k] = hist_bytes[k - 1];
				hist_bytes[0] = v;
				if (hist_fill < MAXL)
					hist_fill++;
				for (int p = 0; p < NPAT; p++)
					if (!res.matched && slot_hit(p)) begin
						res.matched = 1'b1;
						res.slot    = SLOT_W'(p);
					end
				if (res.matched)
					wipe_history();
			end
			ACT_WRITE: begin
				if (s < NPAT && idx < MAXL) begin
					pat_mem[s][idx]     = v;
					pat_written[s][idx] = 1'b1;
				end
			end
			ACT_LENGTH: begin
				if (s < NPAT)
					pat_len[s] = (v > MAXL) ? MAXL : int'(v);
			end
			default: begin
				wipe_history();
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	// Offers one transaction, with an occasional idle burst ahead of it, and
	// records the expected result once it is accepted.
	task automatic send_item(act_t act, logic [SLOT_W-1:0] s, logic [IDX_W-1:0] idx,
			logic [BYTE_W-1:0] v);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		slot       <= s;
		byte_index <= idx;
		value      <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_matches.push_back(predict_match(act, s, idx, v));
		items_sent++;
	endtask

	// Unused fields carry random values so that they are seen to be ignored.
	task automatic stream_byte(logic [BYTE_W-1:0] v);
		send_item(ACT_STREAM, SLOT_W'($urandom), IDX_W'($urandom), v);
	endtask

	task automatic write_byte(int s, int idx, logic [BYTE_W-1:0] v);
		send_item(ACT_WRITE, SLOT_W'(s), IDX_W'(idx), v);
	endtask

	task automatic set_length(int s, int len);
		send_item(ACT_LENGTH, SLOT_W'(s), IDX_W'($urandom), BYTE_W'(len));
	endtask

	task automatic clear_hist();
		send_item(ACT_CLEAR, SLOT_W'($urandom), IDX_W'($urandom), BYTE_W'($urandom));
	endtask

	// The sender goes idle so that the last transaction is not offered again.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
	endtask

	// Half the bytes come from a tiny alphabet so that patterns overlap often.
	function automatic logic [BYTE_W-1:0] random_byte();
		if ($urandom_range(0, 1) == 0)
			return BYTE_W'($urandom_range(8'h41, 8'h44));
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Loads a full pattern into a random slot, then enables it.
	task automatic load_pattern();
		int s;
		int len;
		s   = $urandom_range(0, NPAT - 1);
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAXL) : $urandom_range(1, 4);
		for (int k = 0; k < len; k++)
			write_byte(s, k, random_byte());
		if (len == MAXL && $urandom_range(0, 1) == 1)
			set_length(s, $urandom_range(MAXL + 1, 255));
		else
			set_length(s, len);
	endtask

	// Picks a length that only covers bytes already written.
	task automatic set_legal_length(int s);
		int prefix;
		prefix = 0;
		while (prefix < MAXL && pat_written[s][prefix])
			prefix++;
		if (prefix == MAXL && $urandom_range(0, 1) == 1)
			set_length(s, $urandom_range(0, 255));
		else
			set_length(s, $urandom_range(0, prefix));
	endtask

	// Streams an enabled pattern after a little noise; now and then one byte
	// is flipped so that the run is broken.
	task automatic send_pattern_run();
		int             live[$];
		int             p;
		int             bad;
		logic [BYTE_W-1:0] b;
		for (int s = 0; s < NPAT; s++)
			if (pat_len[s] > 0)
				live.push_back(s);
		if (live.size() == 0) begin
			load_pattern();
			return;
		end
		p = live[$urandom_range(0, live.size() - 1)];
		repeat ($urandom_range(0, 3)) stream_byte(random_byte());
		if ($urandom_range(0, 9) == 0)
			clear_hist();
		bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, pat_len[p] - 1) : -1;
		for (int k = 0; k < pat_len[p]; k++) begin
			b = pat_mem[p][k];
			if (k == bad)
				b = ~b;
			stream_byte(b);
		end
	endtask

	// With every slot disabled, no stream byte can match.
	task automatic test_disabled_slots();
		stream_byte(8'h00);
		stream_byte(8'hff);
		write_byte(NPAT - 1, MAXL - 1, 8'hff);
		write_byte(0, 0, 8'h00);
		set_length(NPAT - 1, 0);
		stream_byte(8'hff);
	endtask

	// Two slots hit on the same byte and the lower one wins; then a clear
	// between the bytes of a pattern prevents its match.
	task automatic test_lowest_slot();
		write_byte(5, 0, 8'h41);
		write_byte(5, 1, 8'h42);
		write_byte(2, 0, 8'h42);
		set_length(5, 2);
		set_length(2, 1);
		stream_byte(8'h41);
		stream_byte(8'h42);
		set_length(2, 0);
		stream_byte(8'h41);
		clear_hist();
		stream_byte(8'h42);
		stream_byte(8'h41);
		stream_byte(8'h42);
	endtask

	// A zero pattern must not match the zeroed history before enough bytes arrive.
	task automatic test_short_history();
		write_byte(4, 0, 8'h00);
		write_byte(4, 1, 8'h00);
		set_length(4, 2);
		clear_hist();
		stream_byte(8'h00);
		stream_byte(8'h00);
		set_length(4, 0);
	endtask

	// A full length pattern enabled by an oversized length, which saturates.
	task automatic test_full_length();
		for (int k = 0; k < MAXL; k++)
			write_byte(NPAT - 1, k, BYTE_W'($urandom_range(0, 255)));
		set_length(NPAT - 1, 255);
		for (int k = 0; k < MAXL; k++)
			stream_byte(pat_mem[NPAT - 1][k]);
		set_length(NPAT - 1, MAXL + 1);
	endtask

	// Mixed traffic, mostly pattern runs with random content.
	task automatic test_random_traffic(int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_pattern_run();
			else if (pick < 60)
				load_pattern();
			else if (pick < 72)
				write_byte($urandom_range(0, NPAT - 1), $urandom_range(0, MAXL - 1),
					random_byte());
			else if (pick < 80)
				set_legal_length($urandom_range(0, NPAT - 1));
			else if (pick < 94)
				stream_byte(random_byte());
			else
				clear_hist();
		end
	endtask

	// Result side: random stall bursts while enabled.
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Compares each accepted result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		match_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_matches.size() == 0) begin
				report_mismatch($sformatf("unexpected result matched=%0b slot=%0d",
					matched, match_slot));
			end else begin
				want = pending_matches.pop_front();
				if (matched !== want.matched)
					report_mismatch($sformatf("matched got %0b want %0b",
						matched, want.matched));
				if (match_slot !== want.slot)
					report_mismatch($sformatf("match_slot got %0d want %0d",
						match_slot, want.slot));
			end
		end
	end

	// Run limit.
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Test sequence.
	initial begin
		errors          = 0;
		items_sent      = 0;
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		wipe_history();
		for (int p = 0; p < NPAT; p++) begin
			pat_len[p] = 0;
			for (int k = 0; k < MAXL; k++)
				pat_written[p][k] = 1'b0;
		end
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_STREAM;
		slot       <= '0;
		byte_index <= '0;
		value      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_slots();
		test_lowest_slot();
		test_short_history();
		test_full_length();
		test_random_traffic(440);
		// Hold off the sender until the block has drained completely.
		wait_for_results();
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		test_random_traffic(150);
		in_valid <= 1'b0;

		wait_for_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
